[sv/buddy_tree_allocator_defines.svh]
// assertion macros for the buddy tree allocator
`ifndef BUDDY_TREE_ALLOCATOR_DEFINES_SVH
`define BUDDY_TREE_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define BTA_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BTA_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/bta_pkg.sv]
// shared types and codes of the buddy tree allocator
`default_nettype none
package bta_pkg;
	localparam logic [1:0] MODE_INIT  = 2'd0;
	localparam logic [1:0] MODE_ALLOC = 2'd1;
	localparam logic [1:0] MODE_FREE  = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_DOUBLE  = 2'd2;
	localparam logic [1:0] ST_RANGE   = 2'd3;

	typedef struct packed {
		logic busy;
		logic done;
		logic range_err;
	} div_sts_t;
endpackage
`default_nettype wire

[sv/buddy_tree_allocator.sv]
// buddy tree allocator top level: config port, sequencer and result register
//
// A binary buddy allocator over 2**LEAF_SHIFT units whose tree lives in one
// memory with two read ports. One item is worked at a time. Init writes every
// leaf (one a cycle) and then rebuilds every inner node from its children.
// Allocate searches the size, descends the tree a level at a time, climbs back
// to update the parents and then computes the address by a multiply and an add.
// Free divides the offset to find the leaf, checks upward for the allocated node
// and then climbs back to update the parents. After reset the tree is cleared
// by an init pass during which no item is taken; configuration writes are
// taken at any time.
`default_nettype none
`include "buddy_tree_allocator_defines.svh"
module buddy_tree_allocator #(
	parameter int LEAF_SHIFT = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [1:0]  mode,
	input  wire logic [31:0] request_bytes,
	input  wire logic [31:0] free_address,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic      [1:0]  status,
	output logic      [31:0] block_address,
	output logic      [9:0]  unit_offset
);
	localparam int L    = LEAF_SHIFT;
	localparam int NW   = L + 1;
	localparam int LW   = $clog2(L + 2);
	localparam int LEAF = 2 ** L;

	localparam logic [1:0] REG_BASE   = 2'd0;
	localparam logic [1:0] REG_UNIT   = 2'd1;
	localparam logic [1:0] REG_USABLE = 2'd2;

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_I_LEAF  = 5'd1;
	localparam logic [4:0] S_I_RD    = 5'd2;
	localparam logic [4:0] S_I_WR    = 5'd3;
	localparam logic [4:0] S_A_SIZE  = 5'd4;
	localparam logic [4:0] S_A_ROOT  = 5'd5;
	localparam logic [4:0] S_A_RCHK  = 5'd6;
	localparam logic [4:0] S_A_RD    = 5'd7;
	localparam logic [4:0] S_A_PICK  = 5'd8;
	localparam logic [4:0] S_A_MARK  = 5'd9;
	localparam logic [4:0] S_C_RD    = 5'd10;
	localparam logic [4:0] S_C_WR    = 5'd11;
	localparam logic [4:0] S_A_MUL   = 5'd12;
	localparam logic [4:0] S_A_ADD   = 5'd13;
	localparam logic [4:0] S_F_DIV   = 5'd14;
	localparam logic [4:0] S_F_RD    = 5'd15;
	localparam logic [4:0] S_F_CHK   = 5'd16;
	localparam logic [4:0] S_F_MARK  = 5'd17;
	localparam logic [4:0] S_DONE    = 5'd18;

	function automatic logic [LW-1:0] merge(input logic [LW-1:0] l, input logic [LW-1:0] r,
		input logic [LW-1:0] c);
		if (l == c && r == c) begin
			return LW'(c + 1'b1);
		end
		return (l > r) ? l : r;
	endfunction

	logic [31:0]   base_q;
	logic [31:0]   unit_cfg_q;
	logic [10:0]   usable_q;
	logic [31:0]   unit_eff;

	logic [4:0]    state_q;
	logic          clr_q;
	logic          is_alloc_q;
	logic [NW-1:0] node_q;
	logic [LW-1:0] h_q;
	logic [LW-1:0] s_q;
	logic [LW-1:0] need_q;
	logic [LW-1:0] remain_q;
	logic [L-1:0]  cnt_q;
	logic [NW-1:0] freeu_q;
	logic [31:0]   req_q;
	logic [31:0]   unit_q;
	logic [L-1:0]  off_q;
	logic [L+31:0] prod_q;
	logic [1:0]    st_q;
	logic [31:0]   blk_q;
	logic [L-1:0]  uoff_q;

	logic          rsp_valid_q;
	logic [1:0]    rsp_status_q;
	logic [31:0]   rsp_block_q;
	logic [9:0]    rsp_uoff_q;

	logic          mem_we;
	logic [NW-1:0] mem_waddr;
	logic [LW-1:0] mem_wdata;
	logic [NW-1:0] mem_ra;
	logic [NW-1:0] mem_rb;
	logic [LW-1:0] rd_a;
	logic [LW-1:0] rd_b;

	logic          div_start;
	logic [L-1:0]  div_q;
	bta_pkg::div_sts_t div_sts;

	logic          accept;
	logic          size_ok;
	logic          pick_r;
	logic [LW-1:0] pick_val;
	logic          take;
	logic          go_right;

	assign unit_eff  = (unit_cfg_q == '0) ? 32'd1 : unit_cfg_q;
	assign pready    = 1'b1;
	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign div_start = accept && mode == bta_pkg::MODE_FREE && free_address >= base_q;

	always_comb begin
		unique case (paddr[3:2])
			REG_BASE:   prdata = base_q;
			REG_UNIT:   prdata = unit_cfg_q;
			REG_USABLE: prdata = {21'd0, usable_q};
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= '0;
			unit_cfg_q <= 32'd1;
			usable_q   <= 11'd1024;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_BASE:   base_q     <= pwdata;
				REG_UNIT:   unit_cfg_q <= pwdata;
				REG_USABLE: usable_q   <= pwdata[10:0];
				default:    ;
			endcase
		end
	end

	assign size_ok  = {{L{1'b0}}, req_q} <= ({{L{1'b0}}, unit_q} << s_q);
	assign pick_r   = rd_a >= rd_b;
	assign pick_val = pick_r ? rd_b : rd_a;
	assign take     = pick_val >= need_q;
	assign go_right = ~(pick_r ^ take);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = node_q;
		mem_wdata = '0;
		mem_ra    = {node_q[NW-2:0], 1'b0};
		mem_rb    = {node_q[NW-2:0], 1'b1};
		unique case (state_q)
			S_I_LEAF: begin
				mem_we    = 1'b1;
				mem_waddr = {1'b1, cnt_q};
				mem_wdata = LW'({1'b0, cnt_q} < freeu_q);
			end
			S_I_WR, S_C_WR: begin
				mem_we    = 1'b1;
				mem_wdata = merge(rd_a, rd_b, h_q);
			end
			S_A_MARK: begin
				mem_we = 1'b1;
			end
			S_F_MARK: begin
				mem_we    = 1'b1;
				mem_wdata = LW'(h_q + 1'b1);
			end
			S_A_ROOT: mem_ra = NW'(1);
			S_F_RD:   mem_ra = node_q;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_I_LEAF;
			clr_q   <= 1'b1;
			freeu_q <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						priority if (mode == bta_pkg::MODE_INIT) begin
							freeu_q <= (32'(usable_q) > 32'(LEAF)) ? NW'(LEAF) : NW'(usable_q);
							cnt_q   <= '0;
							state_q <= S_I_LEAF;
						end else if (mode == bta_pkg::MODE_ALLOC) begin
							state_q <= (request_bytes == '0) ? S_DONE : S_A_SIZE;
						end else if (mode == bta_pkg::MODE_FREE) begin
							state_q <= (free_address < base_q) ? S_DONE : S_F_DIV;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_I_LEAF: begin
					cnt_q <= cnt_q + 1'b1;
					if (&cnt_q) begin
						state_q <= S_I_RD;
					end
				end
				S_I_RD: state_q <= S_I_WR;
				S_I_WR: begin
					if (node_q == NW'(1)) begin
						state_q <= clr_q ? S_IDLE : S_DONE;
						clr_q   <= 1'b0;
					end else begin
						state_q <= S_I_RD;
					end
				end
				S_A_SIZE: begin
					if (size_ok) begin
						state_q <= S_A_ROOT;
					end else if (s_q == LW'(L)) begin
						state_q <= S_DONE;
					end
				end
				S_A_ROOT: state_q <= S_A_RCHK;
				S_A_RCHK: begin
					if (rd_a < need_q) begin
						state_q <= S_DONE;
					end else if (LW'(L + 1) > need_q) begin
						state_q <= S_A_RD;
					end else begin
						state_q <= S_A_MARK;
					end
				end
				S_A_RD: state_q <= S_A_PICK;
				S_A_PICK: state_q <= (LW'(remain_q - 1'b1) > need_q) ? S_A_RD : S_A_MARK;
				S_A_MARK: state_q <= (node_q == NW'(1)) ? S_A_MUL : S_C_RD;
				S_C_RD: state_q <= S_C_WR;
				S_C_WR: begin
					if (node_q == NW'(1)) begin
						state_q <= is_alloc_q ? S_A_MUL : S_DONE;
					end else begin
						state_q <= S_C_RD;
					end
				end
				S_A_MUL: state_q <= S_A_ADD;
				S_A_ADD: state_q <= S_DONE;
				S_F_DIV: begin
					if (div_sts.done) begin
						state_q <= div_sts.range_err ? S_DONE : S_F_RD;
					end
				end
				S_F_RD: state_q <= S_F_CHK;
				S_F_CHK: begin
					if (rd_a == '0) begin
						state_q <= S_F_MARK;
					end else if (node_q == NW'(1)) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_F_RD;
					end
				end
				S_F_MARK: state_q <= (node_q == NW'(1)) ? S_DONE : S_C_RD;
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					req_q      <= request_bytes;
					unit_q     <= unit_eff;
					is_alloc_q <= (mode == bta_pkg::MODE_ALLOC);
					s_q        <= '0;
					blk_q      <= '0;
					uoff_q     <= '0;
					st_q       <= bta_pkg::ST_OK;
					if (mode == bta_pkg::MODE_ALLOC && request_bytes == '0) begin
						st_q <= bta_pkg::ST_NOSPACE;
					end
					if (mode == bta_pkg::MODE_FREE && free_address < base_q) begin
						st_q <= bta_pkg::ST_RANGE;
					end
				end
			end
			S_I_LEAF: begin
				if (&cnt_q) begin
					node_q <= NW'(LEAF - 1);
					h_q    <= LW'(1);
				end
			end
			S_I_WR: begin
				if (node_q != NW'(1)) begin
					node_q <= node_q - 1'b1;
					if ((node_q & (node_q - 1'b1)) == '0) begin
						h_q <= LW'(h_q + 1'b1);
					end
				end
			end
			S_A_SIZE: begin
				need_q <= LW'(s_q + 1'b1);
				if (!size_ok) begin
					s_q <= LW'(s_q + 1'b1);
					if (s_q == LW'(L)) begin
						st_q <= bta_pkg::ST_NOSPACE;
					end
				end
			end
			S_A_RCHK: begin
				node_q   <= NW'(1);
				remain_q <= LW'(L + 1);
				if (rd_a < need_q) begin
					st_q <= bta_pkg::ST_NOSPACE;
				end
			end
			S_A_PICK: begin
				node_q   <= {node_q[NW-2:0], go_right};
				remain_q <= LW'(remain_q - 1'b1);
			end
			S_A_MARK: begin
				off_q  <= L'(node_q << (remain_q - 1'b1));
				uoff_q <= L'(node_q << (remain_q - 1'b1));
				node_q <= node_q >> 1;
				h_q    <= remain_q;
			end
			S_C_WR: begin
				node_q <= node_q >> 1;
				h_q    <= LW'(h_q + 1'b1);
			end
			S_A_MUL: prod_q <= off_q * unit_q;
			S_A_ADD: blk_q <= base_q + prod_q[31:0];
			S_F_DIV: begin
				if (div_sts.done) begin
					if (div_sts.range_err) begin
						st_q <= bta_pkg::ST_RANGE;
					end else begin
						node_q <= {1'b1, div_q};
						uoff_q <= div_q;
						h_q    <= '0;
					end
				end
			end
			S_F_CHK: begin
				if (rd_a != '0) begin
					if (node_q == NW'(1)) begin
						st_q <= bta_pkg::ST_DOUBLE;
					end else begin
						node_q <= node_q >> 1;
						h_q    <= LW'(h_q + 1'b1);
					end
				end
			end
			S_F_MARK: begin
				node_q <= node_q >> 1;
				h_q    <= LW'(h_q + 1'b1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!rsp_valid_q || !rsp_stall)) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!rsp_valid_q || !rsp_stall)) begin
			rsp_status_q <= st_q;
			rsp_block_q  <= blk_q;
			rsp_uoff_q   <= 10'(uoff_q);
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign status        = rsp_status_q;
	assign block_address = rsp_block_q;
	assign unit_offset   = rsp_uoff_q;

	bta_mem #(
		.AW(NW),
		.DW(LW)
	) u_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr_a(mem_ra),
		.raddr_b(mem_rb),
		.rdata_a(rd_a),
		.rdata_b(rd_b)
	);

	bta_div #(
		.LEAF_SHIFT(L)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(free_address - base_q),
		.divisor (unit_eff),
		.quotient(div_q),
		.sts     (div_sts)
	);

	`BTA_ASSERT_IMP(a_no_slot_zero, mem_we, mem_waddr != '0, "write to unused node slot")
	`BTA_ASSERT_NXT(a_rsp_from_done, !rsp_valid, !rsp_valid || $past(state_q) == S_DONE, "result not from done")
	`BTA_ASSERT_IMP(a_climb_height, state_q == S_C_WR, h_q <= LW'(L), "climb above root height")
	`BTA_ASSERT_IMP(a_div_in_free, div_sts.busy, state_q == S_F_DIV, "divider busy outside free")
endmodule
`default_nettype wire

[sv/bta_mem.sv]
// tree level memory, one write port and two registered read ports
`default_nettype none
module bta_mem #(
	parameter int AW = 11,
	parameter int DW = 4
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr_a,
	input  wire logic [AW-1:0] raddr_b,
	output logic      [DW-1:0] rdata_a,
	output logic      [DW-1:0] rdata_b
);
	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule
`default_nettype wire

[sv/bta_div.sv]
// bit-serial divider giving the leaf index of a byte offset
`default_nettype none
module bta_div #(
	parameter int LEAF_SHIFT = 10
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [31:0]           dividend,
	input  wire logic [31:0]           divisor,
	output logic      [LEAF_SHIFT-1:0] quotient,
	output bta_pkg::div_sts_t          sts
);
	localparam int KW = (LEAF_SHIFT > 1) ? $clog2(LEAF_SHIFT) : 1;
	localparam int WW = 32 + LEAF_SHIFT;

	logic            busy_q;
	logic            done_q;
	logic            err_q;
	logic [KW-1:0]   k_q;
	logic [31:0]     rem_q;
	logic [31:0]     dvs_q;
	logic [LEAF_SHIFT-1:0] q_q;
	logic [WW-1:0]   shifted;
	logic            ge;

	assign shifted = {{LEAF_SHIFT{1'b0}}, dvs_q} << k_q;
	assign ge = {{LEAF_SHIFT{1'b0}}, rem_q} >= shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			err_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				err_q <= 1'b0;
				if ({{LEAF_SHIFT{1'b0}}, dividend} >= {divisor, {LEAF_SHIFT{1'b0}}}) begin
					done_q <= 1'b1;
					err_q  <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q && k_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dvs_q <= divisor;
			k_q   <= KW'(LEAF_SHIFT - 1);
			q_q   <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q   <= rem_q - shifted[31:0];
				q_q[k_q] <= 1'b1;
			end
			k_q <= k_q - 1'b1;
		end
	end

	assign quotient      = q_q;
	assign sts.busy      = busy_q;
	assign sts.done      = done_q;
	assign sts.range_err = err_q;
endmodule
`default_nettype wire
